[hdl/timer_handle_pool_core_macros.svh]
// ----------------------------------------------------------------------------
// Timer handle pool assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIMER_HANDLE_POOL_CORE_MACROS_SVH
`define TIMER_HANDLE_POOL_CORE_MACROS_SVH

// Same-cycle implication or plain property.
`define THP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define THP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/thp_pkg.sv]
// ----------------------------------------------------------------------------
// Timer handle pool package
// Sizes, operation codes and the command item passed from front to back end.
// ----------------------------------------------------------------------------
package thp_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int MAX_TICKS  = 30000;

   localparam int OP_W     = 3;
   localparam int HANDLE_W = 4;
   localparam int COUNT_W  = 16;
   localparam int IDX_W    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   // allocate only hands out handles that the handle field can name
   localparam int HANDLE_SPACE = 1 << HANDLE_W;
   localparam int ALLOC_N      = (NUM_TIMERS < HANDLE_SPACE) ? NUM_TIMERS : HANDLE_SPACE;

   // command queue, depth must be a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [IDX_W-1:0]    idx_type;

   localparam count_type MAX_COUNT = COUNT_W'(MAX_TICKS);

   localparam op_type OP_TICK    = 3'd0;
   localparam op_type OP_ALLOC   = 3'd1;
   localparam op_type OP_RESTART = 3'd2;
   localparam op_type OP_READ    = 3'd3;
   localparam op_type OP_RELEASE = 3'd4;
   localparam op_type OP_NONE    = 3'd7;

   typedef struct packed {
      op_type  op;
      logic    hit;
      idx_type idx;
   } cmd_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } qstat_type;

endpackage

[hdl/timer_handle_pool_core.sv]
// ----------------------------------------------------------------------------
// Timer handle pool core
// Pool of software timers on one shared 16-bit tick counter. Each request
// item is one op (tick, allocate, restart, read elapsed, release) and gives
// exactly one response item. The front end decodes a request, registers it
// and parks it in a four-entry command queue. The back end answers tick,
// allocate, restart, release and unknown ops from its idle state and a read
// through a read state (the start time memory has a registered read port).
// A tick that brings the counter to MAX_TICKS walks the start memory, a read
// state then a write state per timer, to rebase busy start times. The
// response register frees the back end as soon as a held item is taken.
// ----------------------------------------------------------------------------
`include "timer_handle_pool_core_macros.svh"

module timer_handle_pool_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  thp_pkg::op_type     req_op,
   input  thp_pkg::handle_type req_handle,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_granted,
   output thp_pkg::handle_type rsp_granted_handle,
   output thp_pkg::count_type  rsp_elapsed
);
   import thp_pkg::*;

   logic      fq_valid;
   logic      fq_ready;
   cmd_type   fq_cmd;
   logic      qb_valid;
   logic      qb_ready;
   cmd_type   qb_cmd;
   qstat_type q_stat;

   thp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_handle (req_handle),
      .cmd_valid  (fq_valid),
      .cmd_ready  (fq_ready),
      .cmd        (fq_cmd)
   );

   thp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_cmd   (fq_cmd),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_cmd    (qb_cmd),
      .stat       (q_stat)
   );

   thp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (qb_valid),
      .cmd_ready          (qb_ready),
      .cmd                (qb_cmd),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_granted        (rsp_granted),
      .rsp_granted_handle (rsp_granted_handle),
      .rsp_elapsed        (rsp_elapsed)
   );

   `THP_ASSERT(a_push_room, (fq_valid && fq_ready) |-> !q_stat.full, "push into full queue")
   `THP_ASSERT(a_pop_avail, (qb_valid && qb_ready) |-> q_stat.not_empty, "pop from empty queue")
   `THP_ASSERT(a_grant_clean, (rsp_valid && rsp_granted) |-> (rsp_elapsed == '0), "grant with elapsed")
   `THP_ASSERT(a_nogrant_zero, (rsp_valid && !rsp_granted) |-> (rsp_granted_handle == '0), "stray handle")
   `THP_ASSERT_NEXT(a_read_slot, (qb_valid && qb_ready && qb_cmd.op == OP_READ), !rsp_valid, "read slot busy")

endmodule

[hdl/thp_front.sv]
// ----------------------------------------------------------------------------
// Timer handle pool front end
// Accepts request items, decodes the op and checks the handle range.
// ----------------------------------------------------------------------------
module thp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  thp_pkg::op_type     req_op,
   input  thp_pkg::handle_type req_handle,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output thp_pkg::cmd_type    cmd
);
   import thp_pkg::*;

   logic    cmd_valid_ff;
   logic    cmd_valid_in;
   cmd_type cmd_ff;
   cmd_type cmd_in;

   always_comb begin
      cmd_in.op  = (req_op inside {[OP_TICK:OP_RELEASE]}) ? req_op : OP_NONE;
      cmd_in.hit = (int'(req_handle) < NUM_TIMERS);
      cmd_in.idx = IDX_W'(req_handle);
   end

   assign req_ready    = !cmd_valid_ff || cmd_ready;
   assign cmd_valid_in = (req_valid && req_ready) || (cmd_valid_ff && !cmd_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

endmodule

[hdl/thp_queue.sv]
// ----------------------------------------------------------------------------
// Timer handle pool command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module thp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  thp_pkg::cmd_type   push_cmd,
   output logic               pop_valid,
   input  logic               pop_ready,
   output thp_pkg::cmd_type   pop_cmd,
   output thp_pkg::qstat_type stat
);
   import thp_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                push;
   logic                pop;

   assign stat.full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.not_empty = (count_ff != '0);
   assign push_ready     = !stat.full;
   assign pop_valid      = stat.not_empty;
   assign pop_cmd        = slot_ff[rd_ptr_ff];
   assign push           = push_valid && push_ready;
   assign pop            = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hdl/thp_back.sv]
// ----------------------------------------------------------------------------
// Timer handle pool back end
// Executes commands against the tick counter, busy flags and start memory,
// and holds the result item in an output register.
// ----------------------------------------------------------------------------
module thp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  thp_pkg::cmd_type     cmd,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_granted,
   output thp_pkg::handle_type  rsp_granted_handle,
   output thp_pkg::count_type   rsp_elapsed
);
   import thp_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_READ    = 2'd1;
   localparam logic [1:0] ST_WALK_RD = 2'd2;
   localparam logic [1:0] ST_WALK_WR = 2'd3;

   localparam idx_type LAST_IDX = IDX_W'(NUM_TIMERS - 1);

   logic [1:0]            state_ff;
   logic [1:0]            state_in;
   count_type             tick_ff;
   count_type             tick_in;
   logic [NUM_TIMERS-1:0] in_use_ff;
   logic [NUM_TIMERS-1:0] in_use_in;
   logic [NUM_TIMERS-1:0] written_ff;
   logic [NUM_TIMERS-1:0] written_in;
   idx_type               walk_ff;
   idx_type               walk_in;
   logic                  hit_ff;
   logic                  hit_in;

   count_type             start_mem [NUM_TIMERS];
   count_type             rd_data_ff;
   logic                  rd_written_ff;
   logic                  mem_we;
   idx_type               mem_addr;
   count_type             mem_wdata;
   count_type             start_eff;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_granted_ff;
   handle_type            rsp_handle_ff;
   count_type             rsp_elapsed_ff;
   logic                  rsp_load;
   logic                  rsp_granted_in;
   handle_type            rsp_handle_in;
   count_type             rsp_elapsed_in;

   logic                  out_free;
   logic                  found;
   handle_type            free_handle;

   // an entry never written reads as the reset value
   assign start_eff = rd_written_ff ? rd_data_ff : '0;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // lowest free handle
   always_comb begin
      found       = 1'b0;
      free_handle = '0;
      for (int i = ALLOC_N - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            found       = 1'b1;
            free_handle = HANDLE_W'(i);
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      tick_in        = tick_ff;
      in_use_in      = in_use_ff;
      written_in     = written_ff;
      walk_in        = walk_ff;
      hit_in         = hit_ff;
      mem_we         = 1'b0;
      mem_addr       = '0;
      mem_wdata      = tick_ff;
      cmd_ready      = 1'b0;
      rsp_load       = 1'b0;
      rsp_granted_in = 1'b0;
      rsp_handle_in  = '0;
      rsp_elapsed_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready = 1'b1;
               case (cmd.op)
                  OP_TICK: begin
                     if (tick_ff == MAX_COUNT - 1'b1) begin
                        // counter wraps: rebase every busy start time
                        tick_in  = '0;
                        walk_in  = '0;
                        state_in = ST_WALK_RD;
                     end else begin
                        tick_in  = tick_ff + 1'b1;
                        rsp_load = 1'b1;
                     end
                  end
                  OP_ALLOC: begin
                     rsp_load = 1'b1;
                     if (found) begin
                        in_use_in[IDX_W'(free_handle)] = 1'b1;
                        rsp_granted_in = 1'b1;
                        rsp_handle_in  = free_handle;
                     end
                  end
                  OP_RESTART: begin
                     rsp_load = 1'b1;
                     if (cmd.hit) begin
                        mem_we              = 1'b1;
                        mem_addr            = cmd.idx;
                        mem_wdata           = tick_ff;
                        written_in[cmd.idx] = 1'b1;
                     end
                  end
                  OP_READ: begin
                     hit_in   = cmd.hit;
                     state_in = ST_READ;
                     if (cmd.hit) begin
                        mem_addr = cmd.idx;
                     end
                  end
                  OP_RELEASE: begin
                     rsp_load = 1'b1;
                     if (cmd.hit) begin
                        in_use_in[cmd.idx] = 1'b0;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            // output slot was freed when the command was taken
            rsp_load = 1'b1;
            if (hit_ff) begin
               rsp_elapsed_in = tick_ff - start_eff;
            end
            state_in = ST_IDLE;
         end
         ST_WALK_RD: begin
            mem_addr = walk_ff;
            state_in = ST_WALK_WR;
         end
         ST_WALK_WR: begin
            if (in_use_ff[walk_ff]) begin
               mem_we              = 1'b1;
               mem_addr            = walk_ff;
               mem_wdata           = start_eff - MAX_COUNT;
               written_in[walk_ff] = 1'b1;
            end
            if (walk_ff == LAST_IDX) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               walk_in  = walk_ff + 1'b1;
               state_in = ST_WALK_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         in_use_ff    <= '0;
         written_ff   <= '0;
         walk_ff      <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         in_use_ff    <= in_use_in;
         written_ff   <= written_in;
         walk_ff      <= walk_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // start time memory, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         start_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff    <= start_mem[mem_addr];
      rd_written_ff <= written_ff[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_granted_ff <= rsp_granted_in;
         rsp_handle_ff  <= rsp_handle_in;
         rsp_elapsed_ff <= rsp_elapsed_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_granted_handle = rsp_handle_ff;
   assign rsp_elapsed        = rsp_elapsed_ff;

endmodule

[dv/timer_handle_pool_core_tb.sv]
// ----------------------------------------------------------------------------
// Timer handle pool core testbench
// Drives tick, allocate, restart, read, release and unused op codes into the
// pool and checks every response item against a cycle-free model of the timer
// pool kept here. Three phases vary sender and receiver idling, and each ends
// with a burst of ticks mixed with random ops and a read of every handle.
// ----------------------------------------------------------------------------
module timer_handle_pool_core_tb;
   import thp_pkg::*;

   localparam op_type OP_SPARE_LO  = OP_RELEASE + 3'd1;
   localparam op_type OP_SPARE_MID = OP_SPARE_LO + 3'd1;
   localparam int     STALL_LIMIT  = 2000;
   localparam int     TAIL_CYCLES  = 50;
   localparam int     RANDOM_OPS   = 152;

   typedef struct packed {
      op_type     op;
      handle_type handle;
   } pool_op_type;

   typedef struct packed {
      logic       granted;
      handle_type granted_handle;
      count_type  elapsed;
   } pool_rsp_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_valid  = 1'b0;
   logic       req_ready;
   op_type     req_op     = OP_TICK;
   handle_type req_handle = '0;
   logic       rsp_valid;
   logic       rsp_ready  = 1'b0;
   logic       rsp_granted;
   handle_type rsp_granted_handle;
   count_type  rsp_elapsed;

   // timer pool shadow state
   count_type pool_ticks;
   count_type timer_start [NUM_TIMERS];
   logic      timer_busy  [NUM_TIMERS];

   pool_op_type  op_backlog [$];
   pool_rsp_type due_rsps   [$];

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   quiet_cycles  = 0;
   int   error_count   = 0;
   int   ops_offered   = 0;
   int   ops_accepted  = 0;
   int   rsps_checked  = 0;
   int   tick_ops      = 0;
   int   wrap_count    = 0;
   int   alloc_misses  = 0;

   timer_handle_pool_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_handle         (req_handle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_granted        (rsp_granted),
      .rsp_granted_handle (rsp_granted_handle),
      .rsp_elapsed        (rsp_elapsed)
   );

   always #5 clock = ~clock;

   function automatic pool_rsp_type pool_apply(input op_type op, input handle_type h);
      pool_rsp_type r;
      logic         h_ok;
      r    = '0;
      h_ok = int'(h) < NUM_TIMERS;
      case (op)
         OP_TICK: begin
            tick_ops++;
            pool_ticks = pool_ticks + 1'b1;
            if (pool_ticks >= MAX_COUNT) begin
               // rebase busy timers only; free ones keep their stale start
               for (int i = 0; i < NUM_TIMERS; i++)
                  if (timer_busy[i])
                     timer_start[i] = timer_start[i] - pool_ticks;
               pool_ticks = '0;
               wrap_count++;
            end
         end
         OP_ALLOC: begin
            for (int i = 0; i < ALLOC_N; i++) begin
               if (!r.granted && !timer_busy[i]) begin
                  timer_busy[i]    = 1'b1;
                  r.granted        = 1'b1;
                  r.granted_handle = handle_type'(i);
               end
            end
            if (!r.granted)
               alloc_misses++;
         end
         OP_RESTART: if (h_ok) timer_start[h] = pool_ticks;
         OP_READ:    if (h_ok) r.elapsed = pool_ticks - timer_start[h];
         OP_RELEASE: if (h_ok) timer_busy[h] = 1'b0;
         default: ;
      endcase
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      $display("mismatch on %s: got %0d, expected %0d (response %0d)",
               what, got, want, rsps_checked);
      error_count++;
   endtask

   // request driver: hold an offered item until taken, then maybe offer the next
   always @(negedge clock) begin : drive_req
      pool_op_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || ops_accepted == ops_offered) begin
         if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt        = op_backlog.pop_front();
            ops_offered++;
            req_valid  <= 1'b1;
            req_op     <= nxt.op;
            req_handle <= nxt.handle;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_rsp_ready
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : watch_ports
      pool_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            due_rsps.push_back(pool_apply(req_op, req_handle));
            ops_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (due_rsps.size() == 0) begin
               flag_mismatch("unexpected response item", 1, 0);
            end else begin
               want = due_rsps.pop_front();
               if (rsp_granted !== want.granted)
                  flag_mismatch("granted", rsp_granted, want.granted);
               if (rsp_granted_handle !== want.granted_handle)
                  flag_mismatch("granted_handle", rsp_granted_handle, want.granted_handle);
               if (rsp_elapsed !== want.elapsed)
                  flag_mismatch("elapsed", rsp_elapsed, want.elapsed);
            end
            rsps_checked++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("timeout: no handshake for %0d cycles, %0d responses outstanding",
                        STALL_LIMIT, due_rsps.size());
               $display("RESULT: ERROR");
               $finish;
            end
         end
      end
   end

   task automatic queue_op(input op_type op, input handle_type h);
      pool_op_type item;
      item.op     = op;
      item.handle = h;
      op_backlog.push_back(item);
   endtask

   // alloc_w trades allocates against releases so the pool fills and empties
   task automatic queue_random(input int count, input int alloc_w);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 30)
            queue_op(OP_TICK, handle_type'($urandom));
         else if (r < 30 + alloc_w)
            queue_op(OP_ALLOC, handle_type'($urandom));
         else if (r < 60)
            queue_op(OP_RELEASE, handle_type'($urandom));
         else if (r < 75)
            queue_op(OP_RESTART, handle_type'($urandom));
         else if (r < 95)
            queue_op(OP_READ, handle_type'($urandom));
         else
            queue_op(op_type'($urandom_range(OP_SPARE_LO, OP_NONE)), handle_type'($urandom));
      end
   endtask

   // hold off until every queued item is taken and every response is back
   task automatic wait_quiet();
      while (op_backlog.size() != 0 || req_valid || due_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase();
      for (int c = 0; c < RANDOM_OPS / 38; c++)
         queue_random(38, (c % 3 == 0) ? 25 : ((c % 3 == 1) ? 5 : 15));
      wait_quiet();
      for (int k = 0; k < 4; k++)
         queue_op(OP_RESTART, handle_type'($urandom));
      // interleave ticks with random ops so elapsed values move between reads
      for (int k = 0; k < 12; k++) begin
         queue_op(OP_TICK, handle_type'($urandom));
         queue_random(1, 15);
      end
      for (int h = 0; h < HANDLE_SPACE; h++)
         queue_op(OP_READ, handle_type'(h));
      wait_quiet();
   endtask

   initial begin
      pool_ticks = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         timer_start[i] = '0;
         timer_busy[i]  = 1'b0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 36;
      recv_idle_pct = 45;
      queue_op(OP_TICK, '0);
      queue_op(OP_READ, '0);
      queue_op(OP_RESTART, '1);
      queue_op(OP_TICK, '1);
      queue_op(OP_READ, '1);
      for (int k = 0; k <= ALLOC_N; k++)
         queue_op(OP_ALLOC, handle_type'(k));
      queue_op(OP_RELEASE, '1);
      queue_op(OP_RELEASE, '1);
      queue_op(OP_ALLOC, '0);
      queue_op(OP_SPARE_LO, '1);
      queue_op(OP_SPARE_MID, '0);
      queue_op(OP_NONE, handle_type'($urandom));
      run_phase();

      send_idle_pct = 45;
      recv_idle_pct = 36;
      run_phase();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d ops (%0d ticks, %0d counter wraps, %0d allocate misses)",
               ops_accepted, tick_ops, wrap_count, alloc_misses);
      $display("checked %0d responses, %0d mismatches", rsps_checked, error_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[timer_handle_pool_core.f]
+incdir+hdl
hdl/thp_pkg.sv
hdl/thp_front.sv
hdl/thp_queue.sv
hdl/thp_back.sv
hdl/timer_handle_pool_core.sv
dv/timer_handle_pool_core_tb.sv
